>>> rtl/core/lpbr_pkg.sv
// ----------------------------------------------------------------------------
// lpbr_pkg
// Shared types, constants and tables of the LED progress bar renderer.
// ----------------------------------------------------------------------------
package lpbr_pkg;

  localparam int MAX_LEDS   = 64;
  localparam int IDX_W      = $clog2(MAX_LEDS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LVL_W      = 16;
  localparam int PCT_W      = 7;
  localparam int ALPHA_W    = 17;
  localparam int COLOR_W    = 24;
  localparam int V_W        = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [PCT_W-1:0]   PCT_MAX        = 7'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'd65536;
  localparam logic [LVL_W-1:0]   DONE_THRESHOLD = 16'd65209;
  localparam logic [LVL_W-1:0]   LVL_MAX        = 16'hFFFF;
  localparam logic [V_W-1:0]     FLOOR_V        = 9'd38;
  localparam logic [V_W-1:0]     FULL_V         = 9'd256;
  localparam logic [V_W-1:0]     PULSE_MID      = 9'd154;
  localparam logic [CNT_W-1:0]   LED_MAX        = CNT_W'(MAX_LEDS);

  // percent to Q1.16: floor(x / 100) as (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
  localparam logic [22:0] TGT_BIAS  = 23'd50;
  localparam logic [23:0] TGT_RECIP = 24'd10737419;
  localparam int          TGT_SHIFT = 30;
  localparam logic [33:0] GLIDE_RND = 34'd32768;

  localparam logic [COLOR_W-1:0] BAR_COLOR_RST  = 24'h00A0FF;
  localparam logic [COLOR_W-1:0] DONE_COLOR_RST = 24'h00FF40;
  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 17'd5190;
  localparam logic [CNT_W-1:0]   LED_COUNT_RST  = 7'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BAR_COLOR   = 3'd0,
    REG_DONE_COLOR  = 3'd1,
    REG_GLIDE_ALPHA = 3'd2,
    REG_LED_COUNT   = 3'd3
  } lpbr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT,
    ST_GLIDE,
    ST_UPD,
    ST_POS,
    ST_PIX
  } lpbr_state_t;

  typedef struct packed {
    logic load_in;
    logic tgt_mul;
    logic glide_mul;
    logic lvl_upd;
    logic pos_mul;
    logic emit;
  } lpbr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_idx;
  } lpbr_sts_t;

  function automatic logic [6:0] quarter_sine(input logic [6:0] j);
    logic [6:0] a;
    unique case (j)
      7'd0:  a = 7'd0;   7'd1:  a = 7'd3;   7'd2:  a = 7'd5;   7'd3:  a = 7'd8;
      7'd4:  a = 7'd10;  7'd5:  a = 7'd13;  7'd6:  a = 7'd15;  7'd7:  a = 7'd18;
      7'd8:  a = 7'd20;  7'd9:  a = 7'd22;  7'd10: a = 7'd25;  7'd11: a = 7'd27;
      7'd12: a = 7'd30;  7'd13: a = 7'd32;  7'd14: a = 7'd34;  7'd15: a = 7'd37;
      7'd16: a = 7'd39;  7'd17: a = 7'd41;  7'd18: a = 7'd44;  7'd19: a = 7'd46;
      7'd20: a = 7'd48;  7'd21: a = 7'd50;  7'd22: a = 7'd53;  7'd23: a = 7'd55;
      7'd24: a = 7'd57;  7'd25: a = 7'd59;  7'd26: a = 7'd61;  7'd27: a = 7'd63;
      7'd28: a = 7'd65;  7'd29: a = 7'd67;  7'd30: a = 7'd69;  7'd31: a = 7'd71;
      7'd32: a = 7'd72;  7'd33: a = 7'd74;  7'd34: a = 7'd76;  7'd35: a = 7'd78;
      7'd36: a = 7'd79;  7'd37: a = 7'd81;  7'd38: a = 7'd82;  7'd39: a = 7'd84;
      7'd40: a = 7'd85;  7'd41: a = 7'd87;  7'd42: a = 7'd88;  7'd43: a = 7'd89;
      7'd44: a = 7'd90;  7'd45: a = 7'd91;  7'd46: a = 7'd93;  7'd47: a = 7'd94;
      7'd48: a = 7'd95;  7'd49: a = 7'd96;  7'd50: a = 7'd96;  7'd51: a = 7'd97;
      7'd52: a = 7'd98;  7'd53: a = 7'd99;  7'd54: a = 7'd99;  7'd55: a = 7'd100;
      7'd56: a = 7'd100; 7'd57: a = 7'd101; 7'd58: a = 7'd101;
      default: a = 7'd102;
    endcase
    return a;
  endfunction

  // 154 +/- folded quarter wave, one full period over 256 phase steps
  function automatic logic [V_W-1:0] pulse_level(input logic [7:0] phase);
    logic [6:0] j;
    logic [6:0] a;
    j = {1'b0, phase[5:0]};
    a = phase[6] ? quarter_sine(7'd64 - j) : quarter_sine(j);
    return phase[7] ? PULSE_MID - {2'b00, a} : PULSE_MID + {2'b00, a};
  endfunction

endpackage

>>> rtl/core/lpbr_ctrl.sv
// ----------------------------------------------------------------------------
// lpbr_ctrl
// Frame sequencer: accepts a request, walks the setup steps, then paces pixels.
// ----------------------------------------------------------------------------
module lpbr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lpbr_pkg::lpbr_sts_t sts,
  output lpbr_pkg::lpbr_cmd_t cmd,
  output lpbr_pkg::lpbr_state_t state
);
  import lpbr_pkg::*;

  lpbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_TGT;
      ST_TGT:   state_nxt = ST_GLIDE;
      ST_GLIDE: state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_PIX;
      ST_PIX:   if (sts.out_free && sts.last_idx) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_TGT:   cmd.tgt_mul   = 1'b1;
      ST_GLIDE: cmd.glide_mul = 1'b1;
      ST_UPD:   cmd.lvl_upd   = 1'b1;
      ST_POS:   cmd.pos_mul   = 1'b1;
      ST_PIX:   cmd.emit      = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

>>> rtl/core/lpbr_dp.sv
// ----------------------------------------------------------------------------
// lpbr_dp
// Datapath: registers, target scaling, glide filter, bar geometry, pixel output.
// ----------------------------------------------------------------------------
module lpbr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lpbr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lpbr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [lpbr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpbr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  lpbr_pkg::lpbr_cmd_t               cmd,
  output lpbr_pkg::lpbr_sts_t               sts
);
  import lpbr_pkg::*;

  // configuration registers
  logic [COLOR_W-1:0] bar_color_r, done_color_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [CNT_W-1:0]   led_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_color_r  <= BAR_COLOR_RST;
      done_color_r <= DONE_COLOR_RST;
      alpha_r      <= ALPHA_RST;
      led_count_r  <= LED_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BAR_COLOR:   bar_color_r  <= cfg_wdata;
        REG_DONE_COLOR:  done_color_r <= cfg_wdata;
        REG_GLIDE_ALPHA: alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        REG_LED_COUNT:   led_count_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [PCT_W-1:0] in_pct;
  logic [7:0]       in_phase;
  assign in_pct   = in_tdata[6:0];
  assign in_phase = in_tdata[14:7];

  logic [PCT_W-1:0]   tl_r;
  logic [7:0]         phase_r;
  logic [CNT_W-1:0]   n_r, n_eff;
  logic [ALPHA_W-1:0] alpha_eff;

  always_comb begin
    n_eff = led_count_r;
    if (led_count_r == '0) n_eff = CNT_W'(1);
    else if (led_count_r > LED_MAX) n_eff = LED_MAX;
  end
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r <= '0;
    end else if (cmd.load_in && in_tuser) begin
      tl_r <= (in_pct > PCT_MAX) ? PCT_MAX : in_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      phase_r <= in_phase;
      n_r     <= n_eff;
    end
  end

  // target in Q1.16 through a reciprocal multiply
  logic [22:0] tgt_num;
  logic [46:0] tmul_r;
  logic [16:0] tgt;
  assign tgt_num = {tl_r, 16'd0} + TGT_BIAS;
  assign tgt     = tmul_r[TGT_SHIFT+16:TGT_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) tmul_r <= tgt_num * TGT_RECIP;
  end

  // glide step: magnitude of the gap times alpha, rounded
  logic [LVL_W-1:0] shown_r, shown_nxt;
  logic             up, up_r;
  logic [16:0]      gap;
  logic [33:0]      gmul_r, grnd;
  logic [16:0]      mag;
  logic [17:0]      sum_up;

  assign up  = tgt >= {1'b0, shown_r};
  assign gap = up ? tgt - {1'b0, shown_r} : {1'b0, shown_r} - tgt;

  always_ff @(posedge clk) begin
    if (cmd.glide_mul) begin
      gmul_r <= gap * alpha_eff;
      up_r   <= up;
    end
  end

  assign grnd   = gmul_r + GLIDE_RND;
  assign mag    = grnd[32:16];
  assign sum_up = {2'b00, shown_r} + {1'b0, mag};

  always_comb begin
    if (up_r) begin
      shown_nxt = (sum_up > {2'b00, LVL_MAX}) ? LVL_MAX : sum_up[LVL_W-1:0];
    end else begin
      shown_nxt = (mag > {1'b0, shown_r}) ? '0 : shown_r - mag[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r <= '0;
    end else if (cmd.lvl_upd) begin
      shown_r <= shown_nxt;
    end
  end

  // bar geometry and pulse brightness
  logic [22:0]      pos;
  logic [IDX_W-1:0] head_r, idx_r;
  logic [7:0]       frac_r;
  logic             done_r;
  logic [V_W-1:0]   pulse_r;

  assign pos = shown_r * n_r;

  always_ff @(posedge clk) begin
    if (cmd.pos_mul) begin
      head_r  <= pos[16+IDX_W-1:16];
      frac_r  <= pos[15:8];
      done_r  <= shown_r >= DONE_THRESHOLD;
      pulse_r <= pulse_level(phase_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_mul) idx_r <= '0;
    else if (cmd.emit) idx_r <= idx_r + IDX_W'(1);
  end

  // pixel brightness and channel scaling
  logic [V_W-1:0]     v_bar, v;
  logic [COLOR_W-1:0] color;
  logic [16:0]        prod_r, prod_g, prod_b;
  logic               is_last;

  always_comb begin
    if (idx_r < head_r) v_bar = FULL_V;
    else if (idx_r == head_r) v_bar = {1'b0, frac_r};
    else v_bar = '0;
    if (v_bar < FLOOR_V) v_bar = FLOOR_V;
  end

  assign v      = done_r ? pulse_r : v_bar;
  assign color  = done_r ? done_color_r : bar_color_r;
  assign prod_r = color[23:16] * v;
  assign prod_g = color[15:8] * v;
  assign prod_b = color[7:0] * v;
  assign is_last = ({1'b0, idx_r} + CNT_W'(1)) == n_r;

  // output register
  logic                  out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {2'b00, prod_b[15:8], prod_g[15:8], prod_r[15:8], idx_r};
      out_last_r <= is_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.last_idx = is_last;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/led_progress_bar_renderer_top.sv
// ----------------------------------------------------------------------------
// led_progress_bar_renderer_top
// LED progress bar renderer: glides a shown level and streams one pixel per LED.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per frame tick; tdata carries target percent and pulse
//           phase, tuser says whether the target percent is taken.
//   out_* : one pixel request per LED, LED 0 first; tlast marks the last LED.
//   cfg_* : register writes (bar color, done color, glide alpha, LED count),
//           only while no frame is in flight.
// Sequence:
//   a frame runs through the accept cycle, four setup steps (target scaling,
//   glide multiply, level update, bar position multiply), then one pixel per
//   cycle from the pixel counter while the output register is free. The first
//   pixel is presented from the output register after the setup steps.
// Stalls: the pixel counter holds while a pixel is pending and out_tready is low;
//   the output register lets the next request be accepted while the last pixel waits.
// Reset: rst_n is synchronous, active low; registers return to their defaults,
//   shown level and target go to zero, no pixel is pending.
// ----------------------------------------------------------------------------
module led_progress_bar_renderer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // target_percent[6:0], pulse_phase[14:7]
  input  logic        in_tuser,   // target_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
  output logic        out_tlast
);
  import lpbr_pkg::*;

  lpbr_cmd_t   cmd;
  lpbr_sts_t   sts;
  lpbr_state_t state;

  lpbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  lpbr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // a pending pixel that is not the last one keeps the input closed
  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("request accepted while a frame is still being emitted");

  // pixel indices run up by one within a frame
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (!out_tvalid || out_tdata[5:0] == $past(out_tdata[5:0]) + 6'd1))
    else $error("pixel index did not advance by one");

  // after an accept the sequencer leaves idle and starts setup
  a_setup_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state == ST_TGT && !in_tready))
    else $error("setup did not start after request");

endmodule

>>> tb/sv/lpbr_pixel_checker.sv
// ----------------------------------------------------------------------------
// lpbr_pixel_checker
// Watches the register port and both streams of the progress bar renderer,
// predicts the pixels of every accepted frame request and compares each
// pixel field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lpbr_pixel_checker
  import lpbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // target_percent[6:0], pulse_phase[14:7]
  input  logic                  in_tuser,   // target_valid
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // pixel_index[5:0], red[13:6], green[21:14],
                                            // blue[29:22]
  input  logic                  out_tlast,
  output int                    pixels_pending,
  output int                    error_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] led;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } pixel_t;

  // round(102.4 * sin), first quarter of the wave
  logic [6:0] sine_amp [0:64] = '{
    0, 3, 5, 8, 10, 13, 15, 18, 20, 22, 25, 27, 30, 32, 34, 37,
    39, 41, 44, 46, 48, 50, 53, 55, 57, 59, 61, 63, 65, 67, 69, 71,
    72, 74, 76, 78, 79, 81, 82, 84, 85, 87, 88, 89, 90, 91, 93, 94,
    95, 96, 96, 97, 98, 99, 99, 100, 100, 101, 101, 102, 102, 102, 102, 102,
    102
  };

  logic [COLOR_W-1:0] bar_rgb;
  logic [COLOR_W-1:0] done_rgb;
  logic [ALPHA_W-1:0] alpha_reg;
  logic [CNT_W-1:0]   count_reg;
  logic [LVL_W-1:0]   shown_lvl;
  logic [PCT_W-1:0]   target_pct;
  pixel_t             pixels_due [$];

  function automatic logic [7:0] dim(input logic [7:0] c, input int v);
    return 8'((int'(c) * v) >> 8);
  endfunction

  function automatic void render_frame(input logic [PCT_W-1:0] pct, input logic take,
                                       input logic [7:0] phase);
    longint goal;
    longint gap;
    longint delta;
    longint level;
    longint alpha;
    longint pos;
    int n;
    int head;
    int frac;
    int v;
    int amp;
    int j;
    logic pulsing;
    logic [COLOR_W-1:0] rgb;
    pixel_t px;
    if (take) target_pct = (pct > PCT_MAX) ? PCT_MAX : pct;
    goal = (longint'(target_pct) * 65536 + 50) / 100;
    alpha = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
    level = longint'(shown_lvl);
    gap = (goal >= level) ? goal - level : level - goal;
    // magnitude rounded to nearest, sign applied afterwards
    delta = (gap * alpha + 32768) >> 16;
    level = (goal >= level) ? level + delta : level - delta;
    if (level < 0) level = 0;
    if (level > 65535) level = 65535;
    shown_lvl = LVL_W'(level);

    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;

    pulsing = (shown_lvl >= DONE_THRESHOLD);
    rgb = pulsing ? done_rgb : bar_rgb;
    pos = longint'(shown_lvl) * n;
    head = int'(pos >> 16);
    frac = int'(pos & 65535);
    j = int'(phase[5:0]);
    amp = phase[6] ? int'(sine_amp[64 - j]) : int'(sine_amp[j]);

    for (int i = 0; i < n; i++) begin
      if (pulsing) begin
        v = phase[7] ? int'(PULSE_MID) - amp : int'(PULSE_MID) + amp;
      end else begin
        if (i < head) v = int'(FULL_V);
        else if (i == head) v = frac >> 8;
        else v = 0;
        if (v < int'(FLOOR_V)) v = int'(FLOOR_V);
      end
      px.led   = IDX_W'(i);
      px.red   = dim(rgb[23:16], v);
      px.green = dim(rgb[15:8], v);
      px.blue  = dim(rgb[7:0], v);
      px.last  = (i + 1 == n);
      pixels_due.push_back(px);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      bar_rgb     = BAR_COLOR_RST;
      done_rgb    = DONE_COLOR_RST;
      alpha_reg   = ALPHA_RST;
      count_reg   = LED_COUNT_RST;
      shown_lvl   = '0;
      target_pct  = '0;
      error_count = 0;
      pixels_due.delete();
    end else begin
      if (cfg_we) begin
        case (lpbr_reg_t'(cfg_addr))
          REG_BAR_COLOR:   bar_rgb   = cfg_wdata[COLOR_W-1:0];
          REG_DONE_COLOR:  done_rgb  = cfg_wdata[COLOR_W-1:0];
          REG_GLIDE_ALPHA: alpha_reg = cfg_wdata[ALPHA_W-1:0];
          REG_LED_COUNT:   count_reg = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // pop before push so a pixel can never match the frame accepted at this edge
      if (out_tvalid && out_tready) begin
        got.led   = out_tdata[5:0];
        got.red   = out_tdata[13:6];
        got.green = out_tdata[21:14];
        got.blue  = out_tdata[29:22];
        got.last  = out_tlast;
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel request: pixel_index %0d", got.led);
          error_count++;
        end else begin
          want = pixels_due.pop_front();
          if (got.led != want.led) begin
            $error("pixel_index mismatch: expected %0d, got %0d", want.led, got.led);
            error_count++;
          end
          if (got.red != want.red) begin
            $error("red mismatch: expected %0d, got %0d", want.red, got.red);
            error_count++;
          end
          if (got.green != want.green) begin
            $error("green mismatch: expected %0d, got %0d", want.green, got.green);
            error_count++;
          end
          if (got.blue != want.blue) begin
            $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
            error_count++;
          end
          if (got.last != want.last) begin
            $error("last_pixel mismatch: expected %0d, got %0d", want.last, got.last);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) render_frame(in_tdata[6:0], in_tuser, in_tdata[14:7]);
    end
    pixels_pending <= pixels_due.size();
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LED progress bar renderer: directed frames over the corner
// settings, then randomized register settings and frame requests under
// changing backpressure, with one long output stall. The pixel checker does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lpbr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 370;
  localparam int HOLD_AT      = 330;
  localparam int HOLD_LEN     = 400;

  // no register lives at this index, writes must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // target_percent[6:0], pulse_phase[14:7]
  logic                  in_tuser   = 1'b0; // target_valid
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
  logic                  out_tlast;

  int pixels_pending;
  int error_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent_cnt      = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycles        = 0;

  led_progress_bar_renderer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lpbr_pixel_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .pixels_pending (pixels_pending),
    .error_count    (error_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sent_cnt <= sent_cnt + 1;
  end

  // pixel sink: random stalls, plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= HOLD_AT && in_tvalid) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_frame(input logic [PCT_W-1:0] pct, input logic take,
                            input logic [7:0] phase);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, phase, pct};
    in_tuser  <= take;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] bar, input logic [CFG_DATA_W-1:0] done_c,
                          input logic [CFG_DATA_W-1:0] alpha_w,
                          input logic [CFG_DATA_W-1:0] count_w);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BAR_COLOR;
    cfg_wdata <= bar;
    @(posedge clk);
    cfg_addr  <= REG_DONE_COLOR;
    cfg_wdata <= done_c;
    @(posedge clk);
    cfg_addr  <= REG_GLIDE_ALPHA;
    cfg_wdata <= alpha_w;
    @(posedge clk);
    cfg_addr  <= REG_LED_COUNT;
    cfg_wdata <= count_w;
    @(posedge clk);
    cfg_addr  <= REG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  initial begin
    int issued;
    int burst;
    int focus;
    logic [ALPHA_W-1:0] alpha;
    logic [CNT_W-1:0]   leds;
    logic [PCT_W-1:0]   pct;
    logic               take;

    issued = 0;
    repeat (9) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 10;
    stall_pct     <= 63;
    @(posedge clk);

    // reset settings: slow glide over ten LEDs
    send_frame(7'd50, 1'b1, 8'd0);
    send_frame(7'd0, 1'b0, 8'd17);

    // immediate jump, full strip, white
    wait_idle();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'h010000, 24'h000040);
    send_frame(7'd100, 1'b1, 8'd0);
    send_frame(7'd0, 1'b0, 8'd63);
    send_frame(7'd0, 1'b0, 8'd64);
    send_frame(7'd0, 1'b0, 8'd127);
    send_frame(7'd0, 1'b0, 8'd128);
    send_frame(7'd0, 1'b0, 8'd192);
    send_frame(7'd0, 1'b0, 8'd255);
    send_frame(7'd127, 1'b1, 8'd170);   // target over 100 saturates
    send_frame(7'd99, 1'b1, 8'd85);     // head on the last LED
    send_frame(7'd0, 1'b1, 8'd0);
    send_frame(7'd1, 1'b1, 8'd0);

    // alpha over one (upper data bits dropped), LED count zero, black pulse
    wait_idle();
    set_regs(24'hA5C3E1, 24'h000000, 24'hFF0001, 24'hFFFF80);
    send_frame(7'd37, 1'b1, 8'd5);
    send_frame(7'd100, 1'b1, 8'd200);

    // alpha zero freezes the level, LED count above the maximum
    wait_idle();
    set_regs(24'hFFFFFF, 24'h5A3C96, 24'h000000, 24'h00007F);
    send_frame(7'd0, 1'b1, 8'd33);
    send_frame(7'd50, 1'b1, 8'd99);

    // smallest alpha creeps down from the full level
    wait_idle();
    set_regs(24'h00A0FF, 24'hFFFFFF, 24'h000001, 24'h000041);
    send_frame(7'd0, 1'b1, 8'd0);
    send_frame(7'd0, 1'b0, 8'd255);

    // single LED, half-way glide
    wait_idle();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'h008000, 24'h000001);
    send_frame(7'd100, 1'b1, 8'd64);
    send_frame(7'd0, 1'b1, 8'd0);

    while (issued < RANDOM_ITEMS) begin
      wait_idle();
      if (issued < RANDOM_ITEMS / 3) begin
        send_idle_pct <= 10;
        stall_pct     <= 63;
      end else if (issued < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct <= 63;
        stall_pct     <= 10;
      end else begin
        send_idle_pct <= 0;
        stall_pct     <= 0;
      end
      case ($urandom_range(5))
        0:       alpha = ALPHA_ONE;
        1:       alpha = 17'd1;
        2:       alpha = ALPHA_W'($urandom);
        default: alpha = ALPHA_W'($urandom_range(2000, 65536));
      endcase
      // mostly short strips keep frames quick
      case ($urandom_range(7))
        0:       leds = LED_MAX;
        1:       leds = 7'd0;
        2:       leds = CNT_W'($urandom_range(65, 127));
        default: leds = CNT_W'($urandom_range(1, 12));
      endcase
      set_regs(pick_color(), pick_color(), {7'($urandom), alpha}, {17'($urandom), leds});

      burst = $urandom_range(20, 50);
      focus = $urandom_range(2);
      repeat (burst) begin
        take = ($urandom_range(3) != 0);
        if (focus == 0) begin
          // steer toward the finished pulse
          pct = ($urandom_range(9) < 7) ? PCT_MAX : PCT_W'($urandom_range(127));
        end else begin
          case ($urandom_range(9))
            0:       pct = PCT_MAX;
            1:       pct = PCT_W'($urandom_range(101, 127));
            2:       pct = 7'd0;
            default: pct = PCT_W'($urandom_range(100));
          endcase
        end
        send_frame(pct, take, 8'($urandom));
        issued++;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
